// ===== sv/gopf_pkg.sv =====
package gopf_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FIN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [7:0] CODE_PIC     = 8'h00;
  localparam logic [7:0] CODE_USER    = 8'hb2;
  localparam logic [7:0] CODE_SEQ     = 8'hb3;
  localparam logic [7:0] CODE_SEQ_END = 8'hb7;

  localparam logic [2:0] TYPE_I = 3'd1;
  localparam logic [2:0] TYPE_P = 3'd2;
  localparam logic [2:0] TYPE_B = 3'd3;

  localparam logic [14:0] CNT_MAX = 15'h7fff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_HIDE,
    ST_REPORT
  } gopf_state_t;

  typedef struct packed {
    logic       sc;
    logic [7:0] code;
    logic [2:0] ptype;
    logic [3:0] bnd;
    logic       hsc;
  } gopf_win_t;

endpackage

// ===== sv/gopf_ram.sv =====
module gopf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/gopf_scan.sv =====
module gopf_scan (
  input  logic                clk,
  input  logic                shift,
  input  logic [7:0]          din,
  input  logic                mark,
  output gopf_pkg::gopf_win_t win
);
  import gopf_pkg::*;

  logic [7:0] o [0:6];
  logic [7:0] m [0:3];

  // advance the original and rewritten byte windows by one position
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int k = 0; k < 6; k++) begin
        o[k] <= o[k+1];
      end
      o[6] <= din;
      m[0] <= m[1];
      m[1] <= m[2];
      m[2] <= mark ? CODE_USER : m[3];
      m[3] <= o[4];
    end
  end

  always_comb begin
    win.sc    = (o[0] == 8'h00) && (o[1] == 8'h00) && (o[2] == 8'h01);
    win.code  = o[3];
    win.ptype = o[5][5:3];
    for (int k = 0; k < 4; k++) begin
      win.bnd[k] = (o[k] == 8'h00) && (o[k+1] == 8'h00) && (o[k+2] == 8'h01) &&
                   ((o[k+3] == CODE_PIC) || (o[k+3] == CODE_SEQ) ||
                    (o[k+3] == CODE_SEQ_END));
    end
    win.hsc   = (m[0] == 8'h00) && (m[1] == 8'h00) && (m[2] == 8'h01);
  end
endmodule

// ===== sv/mpeg2_gop_random_access_filter_top.sv =====
// Buffers an MPEG-2 video stream and cuts it to a clean random access point. A load
// writes its byte at the transfer unless the buffer is full, and a read result is
// registered in the byte store and again in the ST_READ state. A finish walks the
// buffer through the single read port of the byte store, one byte a cycle: a search
// pass over up to the whole byte count, then, when a group qualifies, a rewrite pass
// up to the reference bound, each after a window fill. The block takes no item
// during a read or a finish.
module mpeg2_gop_random_access_filter_top #(
  parameter int BUFFER_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic        terminal,
  input  logic [15:0] read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic        status,
  output logic [15:0] sequence_start,
  output logic [15:0] intra_start,
  output logic [16:0] reference_bound,
  output logic [14:0] preroll_count,
  output logic [14:0] leading_b_count,
  output logic [7:0]  read_data,
  output logic        overflowed
);
  import gopf_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);

  gopf_state_t state, state_next;

  logic [CW-1:0] count;
  logic          ovf;
  logic          term;
  logic          rd_hit;
  logic          rep_ok;
  logic [AW-1:0] ra;
  logic          rd_valid;
  logic [2:0]    filled;
  logic [CW-1:0] p;
  logic [CW-1:0] seq, intra, nref, seg_start;
  logic          have_seq, have_intra, in_seg, seg_drop;
  logic [14:0]   pre, lead;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          shift, mark;
  gopf_win_t     win;

  logic          acc;
  logic          step;
  logic [CW:0]   pw, nw;
  logic          p3_lt_n, p5_lt_n, p_lt_seq, p3_lt_seq, p_lt_nref, p3_lt_nref;
  logic          o_sc, is_pic;
  logic [2:0]    tval;
  logic          scan_go, ref_hit, go_hide, fail;
  logic          hide_go, hide_end;
  logic          cur_in, cur_drop, hide_ok, blk, bnd_here;
  logic [CW-1:0] cur_start;
  logic          pre_inc, lead_inc;

  function automatic logic [14:0] sat_inc(input logic [14:0] v);
    return (v == CNT_MAX) ? v : v + 15'd1;
  endfunction

  assign acc = in_valid && !in_stall;

  always_comb begin
    in_stall = (state != ST_IDLE) ||
               (out_valid && out_stall && ((opcode == OP_FIN) || (opcode == OP_READ)));
  end

  gopf_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gopf_scan u_scan (
    .clk   (clk),
    .shift (shift),
    .din   (ram_rdata),
    .mark  (mark),
    .win   (win)
  );

  assign shift = rd_valid && ((state == ST_SCAN) || (state == ST_HIDE));
  assign step  = shift && (filled == 3'd7);

  always_comb begin
    pw         = {1'b0, p};
    nw         = {1'b0, count};
    p3_lt_n    = (pw + (CW+1)'(3)) < nw;
    p5_lt_n    = (pw + (CW+1)'(5)) < nw;
    p_lt_seq   = p < seq;
    p3_lt_seq  = (pw + (CW+1)'(3)) < {1'b0, seq};
    p_lt_nref  = p < nref;
    p3_lt_nref = (pw + (CW+1)'(3)) < {1'b0, nref};
    o_sc       = win.sc && p3_lt_n;
    is_pic     = o_sc && (win.code == CODE_PIC);
    tval       = p5_lt_n ? win.ptype : 3'd0;
  end

  // search pass
  always_comb begin
    scan_go = (state == ST_SCAN) && step && p5_lt_n;
    ref_hit = is_pic && have_seq && have_intra && ((tval == TYPE_I) || (tval == TYPE_P));
    go_hide = (scan_go && ref_hit) ||
              ((state == ST_SCAN) && step && !p5_lt_n && have_intra && term);
    fail    = (state == ST_SCAN) && step && !p5_lt_n && !(have_intra && term);
  end

  // rewrite pass
  always_comb begin
    hide_go   = (state == ST_HIDE) && step && p_lt_nref;
    hide_end  = (state == ST_HIDE) && step && !p_lt_nref;
    pre_inc   = 1'b0;
    lead_inc  = 1'b0;
    cur_in    = in_seg;
    cur_start = seg_start;
    cur_drop  = seg_drop;
    blk       = 1'b0;
    bnd_here  = 1'b0;
    if (p_lt_seq) begin
      pre_inc = p5_lt_n && is_pic;
      hide_ok = p3_lt_seq;
    end else begin
      bnd_here = win.bnd[0] && p3_lt_n &&
                 (pw >= ({1'b0, seg_start} + (CW+1)'(4)));
      if (!in_seg || bnd_here) begin
        cur_in    = is_pic;
        cur_start = p;
        cur_drop  = (p < intra) || ((p > intra) && (tval == TYPE_B));
        if (is_pic && cur_drop) begin
          pre_inc  = p < intra;
          lead_inc = !(p < intra);
        end
      end
      for (int k = 1; k < 4; k++) begin
        if (win.bnd[k] && ((pw + (CW+1)'(k + 3)) < nw) &&
            ((pw + (CW+1)'(k)) >= ({1'b0, cur_start} + (CW+1)'(4)))) begin
          blk = 1'b1;
        end
      end
      hide_ok = cur_in && cur_drop && p3_lt_nref && !blk;
    end
    mark = hide_go && hide_ok && win.hsc;
  end

  // byte store ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = data_byte;
    ram_raddr = (state == ST_IDLE) ? AW'(read_index) : ra;
    if (state == ST_IDLE) begin
      ram_we = acc && (opcode == OP_LOAD) && (count != CW'(BUFFER_BYTES));
    end else if (mark) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(pw + (CW+1)'(3));
      ram_wdata = CODE_USER;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && (opcode == OP_FIN)) begin
          state_next = ST_SCAN;
        end else if (acc && (opcode == OP_READ)) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_IDLE;
      ST_SCAN: begin
        if (go_hide) begin
          state_next = ST_HIDE;
        end else if (fail) begin
          state_next = ST_REPORT;
        end
      end
      ST_HIDE: begin
        if (hide_end) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
      filled    <= 3'd0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_IDLE) && acc) begin
        case (opcode)
          OP_LOAD: begin
            if (count != CW'(BUFFER_BYTES)) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          OP_CLEAR: begin
            count <= '0;
            ovf   <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if ((state == ST_SCAN) || (state == ST_HIDE)) begin
        if (go_hide || fail || hide_end) begin
          rd_valid <= 1'b0;
          filled   <= 3'd0;
        end else begin
          rd_valid <= 1'b1;
          if (shift && (filled != 3'd7)) begin
            filled <= filled + 3'd1;
          end
        end
      end else begin
        rd_valid <= 1'b0;
        filled   <= 3'd0;
      end
      if ((state == ST_READ) || (state == ST_REPORT)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && acc) begin
      term       <= terminal;
      rd_hit     <= 32'(read_index) < 32'(count);
      ra         <= '0;
      p          <= '0;
      seq        <= '0;
      intra      <= '0;
      nref       <= '0;
      have_seq   <= 1'b0;
      have_intra <= 1'b0;
      rep_ok     <= 1'b0;
    end
    if (state == ST_SCAN) begin
      ra <= ra + AW'(1);
      if (scan_go) begin
        p <= p + CW'(1);
        if (o_sc && (win.code == CODE_SEQ)) begin
          seq        <= p;
          have_seq   <= 1'b1;
          have_intra <= 1'b0;
        end else if (o_sc && (win.code == CODE_SEQ_END) && !have_intra) begin
          have_seq <= 1'b0;
        end else if (is_pic && have_seq && !have_intra && (tval == TYPE_I)) begin
          intra      <= p;
          have_intra <= 1'b1;
        end
      end
      if (go_hide) begin
        nref      <= ref_hit ? p : count;
        rep_ok    <= 1'b1;
        ra        <= '0;
        p         <= '0;
        pre       <= '0;
        lead      <= '0;
        in_seg    <= 1'b0;
        seg_start <= '0;
        seg_drop  <= 1'b0;
      end
    end
    if (state == ST_HIDE) begin
      ra <= ra + AW'(1);
      if (hide_go) begin
        p         <= p + CW'(1);
        in_seg    <= cur_in;
        seg_start <= cur_start;
        seg_drop  <= cur_drop;
        if (pre_inc) begin
          pre <= sat_inc(pre);
        end
        if (lead_inc) begin
          lead <= sat_inc(lead);
        end
      end
    end
    if (state == ST_READ) begin
      kind            <= 1'b1;
      status          <= 1'b0;
      sequence_start  <= '0;
      intra_start     <= '0;
      reference_bound <= '0;
      preroll_count   <= '0;
      leading_b_count <= '0;
      read_data       <= rd_hit ? ram_rdata : 8'h00;
      overflowed      <= ovf;
    end
    if (state == ST_REPORT) begin
      kind            <= 1'b0;
      status          <= rep_ok;
      sequence_start  <= rep_ok ? 16'(seq) : 16'h0000;
      intra_start     <= rep_ok ? 16'(intra) : 16'h0000;
      reference_bound <= rep_ok ? 17'(nref) : 17'h00000;
      preroll_count   <= rep_ok ? pre : 15'h0000;
      leading_b_count <= rep_ok ? lead : 15'h0000;
      read_data       <= 8'h00;
      overflowed      <= ovf;
    end
  end
endmodule

// ===== sv/gopf_checker.sv =====
module gopf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic        status,
  input logic [15:0] sequence_start,
  input logic [15:0] intra_start,
  input logic [16:0] reference_bound,
  input logic [14:0] preroll_count,
  input logic [14:0] leading_b_count,
  input logic [7:0]  read_data
);
  import gopf_pkg::*;

  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && ((opcode == OP_FIN) || (opcode == OP_READ)) |=> in_stall)
    else $error("block took an item right after a finish or read transfer");

  a_need_more_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind && !status |-> sequence_start == 16'h0000 &&
      intra_start == 16'h0000 && reference_bound == 17'h00000 &&
      preroll_count == 15'h0000 && leading_b_count == 15'h0000 && read_data == 8'h00)
    else $error("need-more report carries non-zero fields");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> !status && sequence_start == 16'h0000 &&
      intra_start == 16'h0000 && reference_bound == 17'h00000 &&
      preroll_count == 15'h0000 && leading_b_count == 15'h0000)
    else $error("read result carries report fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status))
    else $error("stalled result changed");
endmodule

bind mpeg2_gop_random_access_filter_top gopf_checker u_gopf_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  import gopf_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  data;
    logic        term;
    logic [15:0] idx;
    int          gap;
    bit          sync;
    bit          hold;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic [15:0] seq_at;
    logic [15:0] intra_at;
    logic [16:0] ref_at;
    logic [14:0] pre;
    logic [14:0] lead;
    logic [7:0]  rdata;
    logic        ovf;
  } rpt_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  opcode = OP_CLEAR;
  logic [7:0]  data_byte = 0;
  logic        terminal = 0;
  logic [15:0] read_index = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        kind, status, overflowed;
  logic [15:0] sequence_start, intra_start;
  logic [16:0] reference_bound;
  logic [14:0] preroll_count, leading_b_count;
  logic [7:0]  read_data;

  mpeg2_gop_random_access_filter_top u_dut (.*);

  req_t        pend[$];
  rpt_t        want_q[$];
  req_t        cur;
  bit          have_cur = 0;
  int          gap_left = 0;
  logic        hold_req = 0;
  int          hold_cnt = 0;
  int          stall_left = 0;
  int          err_cnt = 0;
  bit          calm = 0;
  int unsigned gen_count = 0;

  // predictor state
  logic [7:0]  img [0:65535];
  int unsigned nbytes = 0;
  bit          ovf_f = 0;

  initial forever #5 clk = ~clk;

  function automatic bit sc_at(int unsigned n, int unsigned p);
    return p + 3 < n && img[p] == 8'h00 && img[p+1] == 8'h00 && img[p+2] == 8'h01;
  endfunction

  function automatic logic [2:0] pic_kind(int unsigned n, int unsigned p);
    if (!sc_at(n, p) || img[p+3] != CODE_PIC || p + 5 >= n) return 3'd0;
    return img[p+5][5:3];
  endfunction

  function automatic void hide(int unsigned b, int unsigned e);
    for (int unsigned i = b; i + 3 < e; i++)
      if (img[i] == 8'h00 && img[i+1] == 8'h00 && img[i+2] == 8'h01) img[i+3] = CODE_USER;
  endfunction

  function automatic logic [14:0] sat15(int unsigned v);
    return v > 32767 ? CNT_MAX : v[14:0];
  endfunction

  function automatic rpt_t cut_group(bit term);
    rpt_t r;
    int unsigned n, seq, intra, nref, pre, lead, i, e;
    bit have_seq, have_intra, have_ref, drop;
    logic [2:0] t;
    r = '0;
    r.ovf = ovf_f;
    n = nbytes; seq = 0; intra = 0; nref = 0; pre = 0; lead = 0;
    have_seq = 0; have_intra = 0; have_ref = 0;
    for (i = 0; i + 5 < n; i++) begin
      if (!sc_at(n, i)) continue;
      if (img[i+3] == CODE_SEQ) begin
        seq = i; have_seq = 1; have_intra = 0; continue;
      end
      if (img[i+3] == CODE_SEQ_END && !have_intra) begin
        have_seq = 0; continue;
      end
      if (img[i+3] != CODE_PIC || !have_seq) continue;
      t = pic_kind(n, i);
      if (!have_intra) begin
        if (t == TYPE_I) begin intra = i; have_intra = 1; end
        continue;
      end
      if (t == TYPE_I || t == TYPE_P) begin
        nref = i; have_ref = 1; break;
      end
    end
    if (!have_intra || (!have_ref && !term)) return r;
    if (!have_ref) nref = n;
    for (i = 0; i < seq && i + 5 < n; i++)
      if (sc_at(n, i) && img[i+3] == CODE_PIC) pre++;
    hide(0, seq);
    i = seq;
    while (i < nref) begin
      if (!sc_at(n, i) || img[i+3] != CODE_PIC) begin
        i++; continue;
      end
      t = pic_kind(n, i);
      drop = i < intra || (i > intra && t == TYPE_B);
      e = i + 4;
      while (e < nref) begin
        if (sc_at(n, e) && (img[e+3] == CODE_PIC || img[e+3] == CODE_SEQ ||
                            img[e+3] == CODE_SEQ_END)) break;
        e++;
      end
      if (drop) begin
        hide(i, e);
        if (i < intra) pre++;
        else lead++;
      end
      i = e;
    end
    r.status = 1;
    r.seq_at = seq[15:0];
    r.intra_at = intra[15:0];
    r.ref_at = nref[16:0];
    r.pre = sat15(pre);
    r.lead = sat15(lead);
    return r;
  endfunction

  function automatic void predict(req_t q);
    rpt_t r;
    case (q.op)
      OP_LOAD: begin
        if (nbytes < 65536) begin
          img[nbytes] = q.data; nbytes++;
        end else ovf_f = 1;
      end
      OP_CLEAR: begin
        nbytes = 0; ovf_f = 0;
      end
      OP_FIN: want_q.push_back(cut_group(q.term));
      default: begin
        r = '0;
        r.kind = 1;
        r.ovf = ovf_f;
        if (q.idx < nbytes) r.rdata = img[q.idx];
        want_q.push_back(r);
      end
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      hold_req <= 0;
    end else begin
      hold_req <= in_valid && !in_stall && cur.hold;
      if (in_valid && !in_stall) begin
        predict(cur);
        have_cur = 0;
      end
      if (!(in_valid && in_stall)) begin
        if (!have_cur && pend.size() > 0 && !(pend[0].sync && want_q.size() > 0)) begin
          cur = pend.pop_front();
          have_cur = 1;
          gap_left = cur.gap;
        end
        if (have_cur && gap_left == 0) begin
          in_valid <= 1;
          opcode <= cur.op;
          data_byte <= cur.data;
          terminal <= cur.term;
          read_index <= cur.idx;
        end else begin
          in_valid <= 0;
          if (have_cur) gap_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_cnt <= 0;
    else if (hold_req) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // receiver
  always @(posedge clk) begin
    rpt_t got, want;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {kind, status, sequence_start, intra_start, reference_bound,
               preroll_count, leading_b_count, read_data, overflowed};
        if (want_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected transfer: %p", got);
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) $display("mismatch: want %p got %p", want, got);
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 15);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_cnt > 0 || stall_left > 0;
    end
  end

  function automatic void add(logic [1:0] op, logic [7:0] d = 8'h00, logic t = 1'b0,
                              logic [15:0] ix = 16'h0000, bit sy = 0, bit hd = 0);
    req_t q;
    q.op = op; q.data = d; q.term = t; q.idx = ix; q.sync = sy; q.hold = hd;
    q.gap = calm ? 0 : $urandom_range(0, 15);
    pend.push_back(q);
    if (op == OP_LOAD && gen_count < 65536) gen_count++;
    if (op == OP_CLEAR) gen_count = 0;
  endfunction

  function automatic void add_code(logic [7:0] c);
    add(OP_LOAD, 8'h00); add(OP_LOAD, 8'h00); add(OP_LOAD, 8'h01); add(OP_LOAD, c);
  endfunction

  function automatic void add_noise(int n);
    for (int i = 0; i < n; i++) add(OP_LOAD, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_pic(logic [2:0] t, int body);
    logic [7:0] b;
    add_code(CODE_PIC);
    add(OP_LOAD, 8'($urandom_range(0, 255)));
    b = 8'($urandom_range(0, 255));
    b[5:3] = t;
    add(OP_LOAD, b);
    add_noise(body);
  endfunction

  function automatic void add_reads(int n);
    for (int i = 0; i < n; i++)
      if (gen_count > 0 && $urandom_range(0, 4) != 0)
        add(OP_READ, 8'h00, 1'b0, 16'($urandom_range(0, gen_count - 1)));
      else add(OP_READ, 8'h00, 1'b0, 16'($urandom_range(0, 65535)));
  endfunction

  function automatic void add_stream(int parts);
    int k;
    logic [2:0] t;
    for (int i = 0; i < parts; i++) begin
      k = $urandom_range(0, 9);
      if (k < 2) begin
        add_code(CODE_SEQ); add_noise($urandom_range(0, 6));
      end else if (k == 2) add_code(CODE_SEQ_END);
      else if (k == 3) add_noise($urandom_range(0, 8));
      else if (k == 4) add_code(8'($urandom_range(0, 255)));
      else begin
        t = $urandom_range(0, 4) == 0 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 3));
        add_pic(t, $urandom_range(0, 8));
      end
    end
  endfunction

  initial begin
    int items;
    items = 0;
    // directed
    add(OP_CLEAR);
    add_code(CODE_SEQ); add(OP_LOAD, 8'hff);
    add_pic(TYPE_I, 1); add_pic(TYPE_B, 1); add_pic(TYPE_B, 0); add_pic(TYPE_P, 2);
    add(OP_FIN, 8'h00, 1'b0, 16'h0000, 0, 1);
    add(OP_READ, 8'h00, 1'b0, 16'd0); add(OP_READ, 8'h00, 1'b0, 16'd19);
    add(OP_READ, 8'h00, 1'b0, 16'hffff);
    add(OP_FIN, 8'h00, 1'b1);
    add(OP_CLEAR);
    add_pic(TYPE_P, 0); add_code(CODE_SEQ); add_code(CODE_SEQ_END); add_pic(TYPE_I, 0);
    add(OP_FIN, 8'h00, 1'b1);
    add_code(CODE_SEQ); add_pic(TYPE_I, 0); add_pic(TYPE_B, 1);
    add(OP_FIN, 8'h00, 1'b0); add(OP_FIN, 8'h00, 1'b1, 16'h0000, 1);
    add_reads(3);
    // random
    while (pend.size() < 760 && items < 800) begin
      if ($urandom_range(0, 3) != 0) add(OP_CLEAR);
      add_stream($urandom_range(2, 10));
      add(OP_FIN, 8'h00, 1'($urandom_range(0, 1)), 16'h0000, $urandom_range(0, 7) == 0,
          $urandom_range(0, 15) == 0);
      add_reads($urandom_range(1, 4));
      if ($urandom_range(0, 2) == 0) begin
        add_stream($urandom_range(1, 4));
        add(OP_FIN, 8'h00, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 5) == 0)
        for (int i = 0; i < 4; i++)
          add(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)),
              gen_count > 0 ? 16'($urandom_range(0, gen_count - 1)) : 16'h0000);
      calm = $urandom_range(0, 6) == 0;
      items++;
    end
    // short group, no idling
    calm = 1;
    add(OP_CLEAR, 8'h00, 1'b0, 16'h0000, 1);
    add_code(CODE_SEQ); add_pic(TYPE_I, 3); add_pic(TYPE_B, 3);
    add(OP_FIN, 8'h00, 1'b1);
    add(OP_READ, 8'h00, 1'b0, 16'd3);
    add(OP_CLEAR); add(OP_READ, 8'h00, 1'b0, 16'd1);

    repeat (3) @(posedge clk);
    rst <= 0;
    calm = 0;
    wait (pend.size() == 0 && !have_cur && !in_valid && want_q.size() == 0);
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && want_q.size() == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
